// File: design/fdmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmh_pkg: shared types and constants
// Frame geometry limits, field widths, register indexes and the structs
// passed between the top level and the line buffer.
// ----------------------------------------------------------------------------
package fdmh_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int DIM_W   = 10;
    localparam int PIX_W   = 8;
    localparam int DIFF_W  = PIX_W + 1;
    localparam int SUM_W   = DIFF_W + 2;
    localparam int HIST_W  = 8;
    localparam int HIST_AW = ROW_W + COL_W;
    localparam int HIST_DEPTH = 1 << HIST_AW;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // register values after reset
    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(176);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(120);

    typedef logic signed [DIFF_W-1:0] t_diff;

    // line buffer write request (one per accepted pixel)
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] col;
        t_diff            diff;
    } t_lb_wr;

    // differences of the two previous lines around the current column
    typedef struct packed {
        t_diff older_x;
        t_diff older_x2;
        t_diff newer_x;
        t_diff newer_x1;
    } t_lb_taps;

endpackage

// File: design/fdmh_line_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmh_line_buf: two-line difference buffer
// Holds the pixel differences of the two previous lines. Reads columns
// x, x+1 and x+2 with registered data; the write of the item one stage
// ahead is forwarded into the read data.
// ----------------------------------------------------------------------------
module fdmh_line_buf
    import fdmh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_col,
    input  t_lb_wr           i_wr,
    output t_lb_taps         o_taps
);

    t_diff r_older [MAX_WIDTH];
    t_diff r_newer [MAX_WIDTH];
    t_lb_taps r_taps;

    logic [COL_W-1:0] col_x1;
    logic [COL_W-1:0] col_x2;
    t_diff older_wdata;

    always_comb begin
        col_x1      = i_rd_col + COL_W'(1);
        col_x2      = i_rd_col + COL_W'(2);
        // older line takes over what the newer line held at this column
        older_wdata = r_taps.newer_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_older[i_wr.col] <= older_wdata;
            r_newer[i_wr.col] <= i_wr.diff;
        end
        if (i_rd_en) begin
            r_taps.older_x  <= (i_wr.valid && i_wr.col == i_rd_col) ?
                               older_wdata : r_older[i_rd_col];
            r_taps.older_x2 <= (i_wr.valid && i_wr.col == col_x2) ?
                               older_wdata : r_older[col_x2];
            r_taps.newer_x  <= (i_wr.valid && i_wr.col == i_rd_col) ?
                               i_wr.diff : r_newer[i_rd_col];
            r_taps.newer_x1 <= (i_wr.valid && i_wr.col == col_x1) ?
                               i_wr.diff : r_newer[col_x1];
        end
    end

    assign o_taps = r_taps;

endmodule

// File: design/fdmh_hist_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdmh_hist_ram: motion history frame store
// One write and one registered read per cycle. After reset a sweep writes
// zero to every entry, one per cycle; o_clearing is high meanwhile.
// ----------------------------------------------------------------------------
module fdmh_hist_ram
    import fdmh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [HIST_AW-1:0] i_rd_addr,
    input  logic               i_wr_en,
    input  logic [HIST_AW-1:0] i_wr_addr,
    input  logic [HIST_W-1:0]  i_wr_data,
    output logic [HIST_W-1:0]  o_rd_data,
    output logic               o_clearing
);

    logic [HIST_W-1:0]  r_mem [HIST_DEPTH];
    logic [HIST_W-1:0]  r_rd_data;
    logic               r_clearing;
    logic [HIST_AW-1:0] r_clr_addr;

    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [HIST_W-1:0]  wr_data;

    always_comb begin
        wr_en   = r_clearing || i_wr_en;
        wr_addr = r_clearing ? r_clr_addr : i_wr_addr;
        wr_data = r_clearing ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + HIST_AW'(1);
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

// File: design/frame_diff_motion_history_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_diff_motion_history_top: streaming motion history update
// Turns previous/current luma pairs in raster order into updated motion
// history values at the centres of 3x3 windows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one pixel pair per item in
//   raster order, starting at the top-left of a frame after reset. An item
//   is taken on an edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall) carries one updated history pixel
//   per item with its centre coordinates; o_frame_end marks the last one
//   of a frame. Pixels of the first two rows and last two columns of a
//   line produce no item.
//   Throughput: one item per clock while o_stall is low. A result passes
//   through the pipeline stages and the output register before o_valid shows it.
//   Frame size is set through the write port (index 0 width, 1 height);
//   values are clamped to 3..512. Write only while the block is idle.
//   Reset: counters return to the top-left and the history store is
//   cleared by a sweep over its 262144 entries, one entry per cycle; o_stall is
//   held high until it finishes. Config writes are taken during the sweep.
//   When i_stall holds a result, one more result lands in a skid register
//   and only then does o_stall rise; no item is lost or repeated.
// ----------------------------------------------------------------------------
module frame_diff_motion_history_top
    import fdmh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [DIM_W-1:0]  i_cfg_data,
    // pixel input
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [PIX_W-1:0]  i_prev_pixel,
    input  logic [PIX_W-1:0]  i_cur_pixel,
    // history output
    output logic              o_valid,
    input  logic              i_stall,
    output logic [COL_W-1:0]  o_center_x,
    output logic [ROW_W-1:0]  o_center_y,
    output logic [HIST_W-1:0] o_motion_value,
    output logic              o_frame_end
);

    localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

    typedef struct packed {
        logic [COL_W-1:0]  cx;
        logic [ROW_W-1:0]  cy;
        logic [HIST_W-1:0] value;
        logic              fend;
    } t_res;

    // ------------------------------------------------------------------
    // Configuration: stored already clamped
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] width_clamped;
    logic [DIM_W-1:0] height_clamped;

    always_comb begin
        if (i_cfg_data < DIM_MIN) begin
            width_clamped = DIM_MIN;
        end else if (i_cfg_data > DIM_W'(MAX_WIDTH)) begin
            width_clamped = DIM_W'(MAX_WIDTH);
        end else begin
            width_clamped = i_cfg_data;
        end
        if (i_cfg_data < DIM_MIN) begin
            height_clamped = DIM_MIN;
        end else if (i_cfg_data > DIM_W'(MAX_HEIGHT)) begin
            height_clamped = DIM_W'(MAX_HEIGHT);
        end else begin
            height_clamped = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_width  <= width_clamped;
                REG_FRAME_HEIGHT: r_height <= height_clamped;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline enable
    // The whole pipeline moves while the skid register is empty.
    // ------------------------------------------------------------------
    logic r_skid_full;
    logic clearing;
    logic adv;
    logic accept;

    assign adv     = !r_skid_full;
    assign o_stall = r_skid_full || clearing;
    assign accept  = i_valid && !o_stall;

    // ------------------------------------------------------------------
    // Raster position and window decode at the input
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [DIM_W-1:0] col_ext;
    logic [DIM_W-1:0] row_ext;
    logic [DIM_W-1:0] col_p1;
    logic [DIM_W-1:0] row_p1;
    logic             prod_in;
    logic             fend_in;
    t_diff            diff_in;
    logic [COL_W-1:0] cx_in;
    logic [ROW_W-1:0] cy_in;

    always_comb begin
        col_ext = DIM_W'(r_col);
        row_ext = DIM_W'(r_row);
        col_p1  = col_ext + DIM_W'(1);
        row_p1  = row_ext + DIM_W'(1);
        // a window closes when its bottom-left pixel arrives
        prod_in = (row_ext >= DIM_W'(2)) && (row_ext < r_height)
                  && (col_ext + DIM_W'(2) < r_width);
        fend_in = (col_ext + DIM_W'(3) == r_width) && (row_p1 == r_height);
        diff_in = $signed({1'b0, i_cur_pixel}) - $signed({1'b0, i_prev_pixel});
        cx_in   = r_col + COL_W'(1);
        cy_in   = r_row - ROW_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_p1 >= r_width) begin
                r_col <= '0;
                if (row_p1 >= r_height) begin
                    r_row <= '0;
                end else begin
                    r_row <= row_p1[ROW_W-1:0];
                end
            end else begin
                r_col <= col_p1[COL_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: pixel registered, line buffer and history reads land
    // ------------------------------------------------------------------
    logic             r_s1_valid;
    logic             r_s1_prod;
    logic             r_s1_fend;
    logic [COL_W-1:0] r_s1_col;
    logic [COL_W-1:0] r_s1_cx;
    logic [ROW_W-1:0] r_s1_cy;
    t_diff            r_s1_diff;

    t_lb_wr            lb_wr;
    t_lb_taps          lb_taps;
    logic [HIST_W-1:0] hist_rd;
    logic [SUM_W-1:0]  s1_sum;

    // the stage-1 pixel overwrites its column as it leaves the stage
    always_comb begin
        lb_wr.valid = adv && r_s1_valid;
        lb_wr.col   = r_s1_col;
        lb_wr.diff  = r_s1_diff;
    end

    fdmh_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_rd_en  (adv),
        .i_rd_col (r_col),
        .i_wr     (lb_wr),
        .o_taps   (lb_taps)
    );

    always_comb begin
        s1_sum = SUM_W'(lb_taps.older_x) + SUM_W'(lb_taps.older_x2)
               + SUM_W'(lb_taps.newer_x1) + SUM_W'(r_s1_diff);
    end

    // ------------------------------------------------------------------
    // Stage 2: window sum; floor divide by 4 and magnitude
    // ------------------------------------------------------------------
    logic                    r_s2_valid;
    logic                    r_s2_fend;
    logic [COL_W-1:0]        r_s2_cx;
    logic [ROW_W-1:0]        r_s2_cy;
    logic signed [SUM_W-1:0] r_s2_sum;
    logic [HIST_W-2:0]       r_s2_half;
    logic signed [SUM_W-3:0] s2_quot;
    logic [HIST_W-1:0]       s2_mag;

    always_comb begin
        s2_quot = r_s2_sum[SUM_W-1:2];
        s2_mag  = s2_quot[SUM_W-3] ? HIST_W'(-s2_quot) : HIST_W'(s2_quot);
    end

    // ------------------------------------------------------------------
    // Stage 3: magnitude plus half the old history, written back
    // ------------------------------------------------------------------
    logic              r_s3_valid;
    logic              r_s3_fend;
    logic [COL_W-1:0]  r_s3_cx;
    logic [ROW_W-1:0]  r_s3_cy;
    logic [HIST_W-1:0] r_s3_mag;
    logic [HIST_W-2:0] r_s3_half;
    t_res              res;
    logic              res_valid;

    always_comb begin
        res.cx    = r_s3_cx;
        res.cy    = r_s3_cy;
        res.value = r_s3_mag + HIST_W'(r_s3_half);
        res.fend  = r_s3_fend;
        res_valid = adv && r_s3_valid;
    end

    fdmh_hist_ram u_hist_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (adv),
        .i_rd_addr  ({cy_in, cx_in}),
        .i_wr_en    (res_valid),
        .i_wr_addr  ({r_s3_cy, r_s3_cx}),
        .i_wr_data  (res.value),
        .o_rd_data  (hist_rd),
        .o_clearing (clearing)
    );

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid && r_s1_prod;
            r_s3_valid <= r_s2_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_prod <= prod_in;
            r_s1_fend <= fend_in;
            r_s1_col  <= r_col;
            r_s1_cx   <= cx_in;
            r_s1_cy   <= cy_in;
            r_s1_diff <= diff_in;

            r_s2_fend <= r_s1_fend;
            r_s2_cx   <= r_s1_cx;
            r_s2_cy   <= r_s1_cy;
            r_s2_sum  <= s1_sum;
            r_s2_half <= hist_rd[HIST_W-1:1];

            r_s3_fend <= r_s2_fend;
            r_s3_cx   <= r_s2_cx;
            r_s3_cy   <= r_s2_cy;
            r_s3_mag  <= s2_mag;
            r_s3_half <= r_s2_half;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid register
    // ------------------------------------------------------------------
    logic r_out_valid;
    t_res r_out;
    t_res r_skid;
    logic out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_skid_full || res_valid;
            r_skid_full <= 1'b0;
        end else if (res_valid) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_full ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_center_x     = r_out.cx;
    assign o_center_y     = r_out.cy;
    assign o_motion_value = r_out.value;
    assign o_frame_end    = r_out.fend;

endmodule
